FILE: hw/rtl/dcs_bfp_pkg.sv
// ----------------------------------------------------------------------------
// dcs_bfp_pkg
// Types, codes and small decode tables shared by the DCS block field parser.
// ----------------------------------------------------------------------------
package dcs_bfp_pkg;

  // Field sequencer states, one-hot
  typedef enum logic [17:0] {
    FLD_TYPE  = 18'd1,
    FLD_LEN   = 18'd2,
    FLD_SEQ   = 18'd4,
    FLD_FLAGS = 18'd8,
    FLD_ARM   = 18'd16,
    FLD_ADDR  = 18'd32,
    FLD_START = 18'd64,
    FLD_END   = 18'd128,
    FLD_STR   = 18'd256,
    FLD_OFF   = 18'd512,
    FLD_NOISE = 18'd1024,
    FLD_PHASE = 18'd2048,
    FLD_CHAN  = 18'd4096,
    FLD_SRC   = 18'd8192,
    FLD_SEC   = 18'd16384,
    FLD_DATA  = 18'd32768,
    FLD_CRC   = 18'd65536,
    FLD_SKIP  = 18'd131072
  } fld_e;

  // Token ids on the output
  typedef enum logic [4:0] {
    TOK_TYPE      = 5'd0,
    TOK_LENGTH    = 5'd1,
    TOK_SEQ       = 5'd2,
    TOK_BAUD      = 5'd3,
    TOK_PLATFORM  = 5'd4,
    TOK_ARM       = 5'd5,
    TOK_ADDRESS   = 5'd6,
    TOK_START     = 5'd7,
    TOK_END       = 5'd8,
    TOK_STRENGTH  = 5'd9,
    TOK_OFFSET    = 5'd10,
    TOK_NOISE     = 5'd11,
    TOK_MODIDX    = 5'd12,
    TOK_PHASE     = 5'd13,
    TOK_CHANNEL   = 5'd14,
    TOK_CRAFT     = 5'd15,
    TOK_SOURCE    = 5'd16,
    TOK_SECONDARY = 5'd17,
    TOK_DATACHAR  = 5'd18,
    TOK_BLOCKEND  = 5'd19
  } tok_id_e;

  localparam int unsigned ValW = 56;

  // Block type codes with a decoded layout
  localparam logic [7:0] BLK_MESSAGE = 8'd1;
  localparam logic [7:0] BLK_MISSED  = 8'd2;

  // Output token queue
  localparam int unsigned TokqDepth = 4;
  localparam int unsigned TokqPtrW  = $clog2(TokqDepth);
  localparam int unsigned TokqCntW  = $clog2(TokqDepth + 1);

  typedef struct packed {
    logic [4:0]      id;
    logic [ValW-1:0] value;
    logic            last;
  } tok_t;

  // Up to two tokens produced by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

  function automatic tok_t mk_tok(tok_id_e id, logic [ValW-1:0] value);
    tok_t t;
    t.id    = id;
    t.value = value;
    t.last  = 1'b0;
    return t;
  endfunction

  // Bytes in each field
  function automatic logic [2:0] field_len(fld_e f);
    logic [2:0] n;
    unique case (f)
      FLD_LEN, FLD_STR, FLD_OFF, FLD_NOISE, FLD_CHAN,
      FLD_SRC, FLD_SEC, FLD_CRC:   n = 3'd2;
      FLD_SEQ:                     n = 3'd3;
      FLD_ADDR:                    n = 3'd4;
      FLD_START, FLD_END:          n = 3'd7;
      default:                     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [10:0] baud_of(logic [2:0] code);
    logic [10:0] r;
    unique case (code)
      3'd1:    r = 11'd100;
      3'd2:    r = 11'd300;
      3'd3:    r = 11'd1200;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

  // Modulation index letter "XNHL"
  function automatic logic [7:0] mod_char(logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = 8'h58;
      2'd1: r = 8'h4E;
      2'd2: r = 8'h48;
      2'd3: r = 8'h4C;
      default: r = 8'h58;
    endcase
    return r;
  endfunction

  // Spacecraft letter "XEWCT", unknown codes give X
  function automatic logic [7:0] craft_char(logic [3:0] k);
    logic [7:0] r;
    unique case (k)
      4'd1:    r = 8'h45;
      4'd2:    r = 8'h57;
      4'd3:    r = 8'h43;
      4'd4:    r = 8'h54;
      default: r = 8'h58;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/dcs_bfp_decode.sv
// ----------------------------------------------------------------------------
// dcs_bfp_decode
// Parser state registers and the single-pass byte decode producing tokens.
// ----------------------------------------------------------------------------
module dcs_bfp_decode #(
  parameter int unsigned HEADER_BYTES        = 64,
  parameter int unsigned FIXED_MESSAGE_BYTES = 41
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  file_start_i,
  input  logic                  trailer_i,
  output dcs_bfp_pkg::tok_pair_t pair_o
);
  import dcs_bfp_pkg::*;

  localparam int unsigned HdrW = $clog2(HEADER_BYTES + 1);

  logic [HdrW-1:0] hdr_q, hdr_d, hdr_e;
  fld_e            fld_q, fld_d, fld_e_s;
  logic [2:0]      bif_q, bif_d, bif_e, bif_new;
  logic [ValW-1:0] acc_q, acc_d, acc_e, acc_new;
  logic [7:0]      typ_q, typ_d, typ_e;
  logic [15:0]     left_q, left_d, left_e, left_dec;
  logic            done;
  tok_pair_t       pr;

  always_comb begin
    // effective state: a file start clears everything first
    if (file_start_i) begin
      hdr_e   = '0;
      fld_e_s = FLD_TYPE;
      bif_e   = '0;
      acc_e   = '0;
      typ_e   = '0;
      left_e  = '0;
    end else begin
      hdr_e   = hdr_q;
      fld_e_s = fld_q;
      bif_e   = bif_q;
      acc_e   = acc_q;
      typ_e   = typ_q;
      left_e  = left_q;
    end

    acc_new = acc_e;
    for (int i = 0; i < 7; i++) begin
      if (bif_e == 3'(i)) acc_new[8*i +: 8] = acc_e[8*i +: 8] | data_byte_i;
    end
    bif_new  = bif_e + 3'd1;
    done     = (bif_new == field_len(fld_e_s));
    left_dec = (left_e != 16'd0) ? left_e - 16'd1 : left_e;

    hdr_d  = hdr_e;
    fld_d  = fld_e_s;
    bif_d  = bif_e;
    acc_d  = acc_e;
    typ_d  = typ_e;
    left_d = left_e;
    pr     = '0;

    if (trailer_i) begin
      // CRC trailer byte: no change beyond a possible file start
    end else if (hdr_e < HdrW'(HEADER_BYTES)) begin
      hdr_d = hdr_e + HdrW'(1);
    end else if (fld_e_s == FLD_DATA) begin
      pr.cnt = 2'd1;
      pr.t0  = mk_tok(TOK_DATACHAR, ValW'(data_byte_i[6:0]));
      left_d = left_dec;
      if (left_dec == 16'd0) begin
        fld_d = FLD_CRC;
        bif_d = '0;
        acc_d = '0;
      end
    end else if (fld_e_s == FLD_SKIP) begin
      left_d = left_dec;
      if (left_dec == 16'd0) begin
        pr.cnt = 2'd1;
        pr.t0  = mk_tok(TOK_BLOCKEND, ValW'(typ_e));
        fld_d  = FLD_TYPE;
        bif_d  = '0;
        acc_d  = '0;
      end
    end else if (!done) begin
      bif_d = bif_new;
      acc_d = acc_new;
    end else begin
      bif_d  = '0;
      acc_d  = '0;
      pr.cnt = 2'd1;
      unique case (fld_e_s)
        FLD_TYPE: begin
          typ_d = acc_new[7:0];
          pr.t0 = mk_tok(TOK_TYPE, ValW'(acc_new[7:0]));
          fld_d = FLD_LEN;
        end
        FLD_LEN: begin
          pr.t0 = mk_tok(TOK_LENGTH, ValW'(acc_new[15:0]));
          if (typ_e == BLK_MESSAGE) begin
            left_d = (acc_new[15:0] > 16'(FIXED_MESSAGE_BYTES)) ?
                     acc_new[15:0] - 16'(FIXED_MESSAGE_BYTES) : 16'd0;
            fld_d  = FLD_SEQ;
          end else if (typ_e == BLK_MISSED) begin
            fld_d = FLD_SEQ;
          end else if (acc_new[15:0] > 16'd3) begin
            left_d = acc_new[15:0] - 16'd3;
            fld_d  = FLD_SKIP;
          end else begin
            pr.cnt = 2'd2;
            pr.t1  = mk_tok(TOK_BLOCKEND, ValW'(typ_e));
            fld_d  = FLD_TYPE;
          end
        end
        FLD_SEQ: begin
          pr.t0 = mk_tok(TOK_SEQ, ValW'(acc_new[23:0]));
          fld_d = FLD_FLAGS;
        end
        FLD_FLAGS: begin
          pr.t0 = mk_tok(TOK_BAUD, ValW'(baud_of(acc_new[2:0])));
          if (typ_e == BLK_MESSAGE) begin
            pr.cnt = 2'd2;
            pr.t1  = mk_tok(TOK_PLATFORM, acc_new[3] ? ValW'(2) : ValW'(1));
            fld_d  = FLD_ARM;
          end else begin
            fld_d = FLD_ADDR;
          end
        end
        FLD_ARM: begin
          pr.t0 = mk_tok(TOK_ARM, ValW'(acc_new[7:0]));
          fld_d = FLD_ADDR;
        end
        FLD_ADDR: begin
          pr.t0 = mk_tok(TOK_ADDRESS, ValW'(acc_new[31:0]));
          fld_d = FLD_START;
        end
        FLD_START: begin
          pr.t0 = mk_tok(TOK_START, acc_new);
          fld_d = FLD_END;
        end
        FLD_END: begin
          pr.t0 = mk_tok(TOK_END, acc_new);
          fld_d = (typ_e == BLK_MESSAGE) ? FLD_STR : FLD_CHAN;
        end
        FLD_STR: begin
          pr.t0 = mk_tok(TOK_STRENGTH, ValW'(acc_new[9:0]));
          fld_d = FLD_OFF;
        end
        FLD_OFF: begin
          pr.t0 = mk_tok(TOK_OFFSET, ValW'(acc_new[13:0]));
          fld_d = FLD_NOISE;
        end
        FLD_NOISE: begin
          pr.cnt = 2'd2;
          pr.t0  = mk_tok(TOK_NOISE, ValW'(acc_new[11:0]));
          pr.t1  = mk_tok(TOK_MODIDX, ValW'(mod_char(acc_new[15:14])));
          fld_d  = FLD_PHASE;
        end
        FLD_PHASE: begin
          pr.t0 = mk_tok(TOK_PHASE, ValW'(acc_new[7:0]));
          fld_d = FLD_CHAN;
        end
        FLD_CHAN: begin
          pr.cnt = 2'd2;
          pr.t0  = mk_tok(TOK_CHANNEL, ValW'(acc_new[9:0]));
          pr.t1  = mk_tok(TOK_CRAFT, ValW'(craft_char(acc_new[15:12])));
          fld_d  = (typ_e == BLK_MESSAGE) ? FLD_SRC : FLD_CRC;
        end
        FLD_SRC: begin
          pr.t0 = mk_tok(TOK_SOURCE, ValW'(acc_new[15:0]));
          fld_d = FLD_SEC;
        end
        FLD_SEC: begin
          pr.t0 = mk_tok(TOK_SECONDARY, ValW'(acc_new[15:0]));
          fld_d = (left_e != 16'd0) ? FLD_DATA : FLD_CRC;
        end
        default: begin
          // block CRC closes the block
          pr.t0 = mk_tok(TOK_BLOCKEND, ValW'(typ_e));
          fld_d = FLD_TYPE;
        end
      endcase
    end

    if (pr.cnt == 2'd1) pr.t0.last = 1'b1;
    if (pr.cnt == 2'd2) pr.t1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= '0;
      fld_q  <= FLD_TYPE;
      bif_q  <= '0;
      acc_q  <= '0;
      typ_q  <= '0;
      left_q <= '0;
    end else if (step_i) begin
      hdr_q  <= hdr_d;
      fld_q  <= fld_d;
      bif_q  <= bif_d;
      acc_q  <= acc_d;
      typ_q  <= typ_d;
      left_q <= left_d;
    end
  end

  assign pair_o = pr;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> pr.cnt != 2'd3)
    else $error("token count out of range");

  a_trailer_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && trailer_i) |-> pr.cnt == 2'd0)
    else $error("trailer byte produced a token");

  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && pr.cnt == 2'd2) |-> (pr.t1.last && !pr.t0.last))
    else $error("run_last misplaced on token pair");

endmodule

FILE: hw/rtl/dcs_bfp_tokq.sv
// ----------------------------------------------------------------------------
// dcs_bfp_tokq
// Small token queue: takes up to two tokens per cycle while it has room for two, hands out one.
// ----------------------------------------------------------------------------
module dcs_bfp_tokq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dcs_bfp_pkg::tok_pair_t push_i,
  output logic                   room_o,
  output dcs_bfp_pkg::tok_t      head_o,
  output logic                   valid_o,
  input  logic                   pop_i
);
  import dcs_bfp_pkg::*;

  tok_t                mem_q [TokqDepth];
  logic [TokqPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [TokqCntW-1:0] count_q, count_d;
  logic                pop;

  assign pop     = pop_i && (count_q != '0);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room_o  = (count_q <= TokqCntW'(TokqDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + TokqPtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + TokqPtrW'(pop);
    count_d  = count_q + TokqCntW'(push_i.cnt) - TokqCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.t0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_q + TokqPtrW'(1)] <= push_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TokqCntW'(TokqDepth))
    else $error("token queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("tokens pushed without room");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> count_q == $past(count_q) - TokqCntW'(1))
    else $error("pop did not drain queue");

endmodule

FILE: hw/rtl/dcs_block_field_parser_unit.sv
// ----------------------------------------------------------------------------
// dcs_block_field_parser_unit
// DCS file byte parser: skips the file header and CRC trailer and turns
// message and missed-message blocks into (field_id, field_value) tokens.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o | data_byte_i, file_start_i,
//          |           |                         | trailer_i
//  out     | output    | out_valid_o/out_ready_i | field_id_o, field_value_o,
//          |           |                         | run_last_o
//
//  Flow: one byte per clock while in_ready_o is high. A byte is decoded in
//    the cycle it transfers and its tokens are registered into the queue.
//    Two tokens from one byte leave the single-token output port in turn.
//  Stalls: in_ready_o is high while the 4-entry token queue has room for two
//    tokens, so input keeps flowing while a token waits on out_ready_i.
//  Reset: rst_ni clears the parser to the start of a file (header counting)
//    and empties the token queue. No clearing pass.
//
module dcs_block_field_parser_unit #(
  parameter int unsigned HEADER_BYTES        = 64,
  parameter int unsigned FIXED_MESSAGE_BYTES = 41
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  input  logic        trailer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  field_id_o,
  output logic [55:0] field_value_o,
  output logic        run_last_o
);
  import dcs_bfp_pkg::*;

  logic      step;   // input transfer this cycle
  logic      room;
  tok_pair_t pair;   // tokens from the current byte
  tok_pair_t push;   // gated by the transfer
  tok_t      head;

  assign in_ready_o = room;
  assign step       = in_valid_i && room;

  // Byte decode and parser state
  dcs_bfp_decode #(
    .HEADER_BYTES       (HEADER_BYTES),
    .FIXED_MESSAGE_BYTES(FIXED_MESSAGE_BYTES)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_byte_i),
    .file_start_i(file_start_i),
    .trailer_i   (trailer_i),
    .pair_o      (pair)
  );

  always_comb begin
    push = pair;
    if (!step) push.cnt = 2'd0;
  end

  // Output token queue doubles as the result register
  dcs_bfp_tokq u_tokq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .head_o (head),
    .valid_o(out_valid_o),
    .pop_i  (out_ready_i)
  );

  assign field_id_o    = head.id;
  assign field_value_o = head.value;
  assign run_last_o    = head.last;

endmodule
